// ----- hw/rtl/sorm_pkg.sv -----
// shared types, constants and codes for the single-owner memory port
package sorm_pkg;

    localparam int LINE_WORDS      = 4;
    localparam int ADDR_BITS       = 20;
    localparam int WORD_BITS       = 32;
    localparam int OFFSET_BITS     = $clog2(LINE_WORDS);
    localparam int RAW_ADDR_BITS   = 32;
    localparam int MAG_BITS        = RAW_ADDR_BITS - OFFSET_BITS;
    localparam int STEP_BITS       = $clog2(MAG_BITS);
    localparam int LINE_COUNT_BITS = 19;
    localparam int MAX_LINES       = 2 ** (ADDR_BITS - OFFSET_BITS);
    localparam int LINE_BASE_BITS  = 20;
    localparam int ACTION_BITS     = 2;
    localparam int STAGE_BITS      = 3;
    localparam int KIND_BITS       = 2;

    localparam logic [LINE_COUNT_BITS-1:0] LINE_COUNT_RESET = LINE_COUNT_BITS'(256);

    // request actions
    localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CANCEL = 2'd2;

    // kind of request held by the owner
    localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_STORE = 2'd2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0]        action;
        logic [STAGE_BITS-1:0]         requester;
        logic signed [RAW_ADDR_BITS-1:0] address;
        word_t                         store_value;
        logic                          read_ready;
        logic                          write_ready;
        word_t [LINE_WORDS-1:0]        line_word;
    } item_t;

    typedef struct packed {
        logic                          must_wait;
        word_t                         load_value;
        logic [STAGE_BITS-1:0]         owner_stage;
        logic                          mem_read;
        logic                          mem_write;
        logic                          mem_abort;
        logic [LINE_BASE_BITS-1:0]     line_base;
        word_t [LINE_WORDS-1:0]        write_word;
    } result_t;

endpackage

// ----- hw/rtl/sorm_wrap.sv -----
// iterative address wrap unit: floor modulo of a signed word address by the memory size
module sorm_wrap
    import sorm_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [RAW_ADDR_BITS-1:0] address,
    input  logic [LINE_COUNT_BITS-1:0]      line_count,
    output logic                            done,
    output logic [ADDR_BITS-1:0]            norm
);

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_ITER = 3'b010,
        W_FOLD = 3'b100
    } wrap_state_t;

    wrap_state_t                 state_reg, state_next;
    logic [STEP_BITS-1:0]        step_reg, step_next;
    logic                        done_reg, done_next;
    logic [LINE_COUNT_BITS-1:0]  lines_reg, lines_next;
    logic [MAG_BITS-1:0]         mag_reg, mag_next;
    logic [LINE_COUNT_BITS-1:0]  rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic [OFFSET_BITS-1:0]      low_reg, low_next;

    logic [LINE_COUNT_BITS:0]    trial;
    logic [LINE_COUNT_BITS-1:0]  lines_clamped;
    logic [MAG_BITS-1:0]         quarter;

    always_comb
    begin
        if (line_count == '0)
        begin
            lines_clamped = LINE_COUNT_BITS'(1);
        end
        else if (line_count > LINE_COUNT_BITS'(MAX_LINES))
        begin
            lines_clamped = LINE_COUNT_BITS'(MAX_LINES);
        end
        else
        begin
            lines_clamped = line_count;
        end
    end

    // word address = line index * LINE_WORDS + low bits, so only the high part needs a modulo
    assign quarter = address[RAW_ADDR_BITS-1:OFFSET_BITS];
    assign trial   = {rem_reg, mag_reg[MAG_BITS-1]};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        lines_next = lines_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        low_next   = low_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    lines_next = lines_clamped;
                    neg_next   = address[RAW_ADDR_BITS-1];
                    mag_next   = address[RAW_ADDR_BITS-1] ? (~quarter + MAG_BITS'(1)) : quarter;
                    low_next   = address[OFFSET_BITS-1:0];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = W_ITER;
                end
            end
            W_ITER:
            begin
                // one restoring remainder step per cycle
                if (trial >= {1'b0, lines_reg})
                begin
                    rem_next = LINE_COUNT_BITS'(trial - {1'b0, lines_reg});
                end
                else
                begin
                    rem_next = trial[LINE_COUNT_BITS-1:0];
                end
                mag_next  = {mag_reg[MAG_BITS-2:0], 1'b0};
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(MAG_BITS - 1))
                begin
                    state_next = W_FOLD;
                end
            end
            W_FOLD:
            begin
                // negative address with nonzero remainder folds up
                if (neg_reg && (rem_reg != '0))
                begin
                    rem_next = lines_reg - rem_reg;
                end
                done_next  = 1'b1;
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lines_reg <= lines_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        low_reg   <= low_next;
    end

    assign done = done_reg;
    assign norm = {rem_reg[ADDR_BITS-OFFSET_BITS-1:0], low_reg};

endmodule

// ----- hw/rtl/sorm_port.sv -----
// ownership tracking and load / store read-merge-write sequencing
module sorm_port
    import sorm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  item_t                item,
    input  logic [ADDR_BITS-1:0] norm,
    output result_t              res
);

    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [STAGE_BITS-1:0]  owner_reg, owner_next;
    logic [ADDR_BITS-1:0]   held_addr_reg, held_addr_next;
    word_t                  held_word_reg, held_word_next;
    logic                   phase_reg, phase_next;
    word_t [LINE_WORDS-1:0] merged_reg, merged_next;

    always_comb
    begin
        logic [KIND_BITS-1:0]      want_kind;
        logic [OFFSET_BITS-1:0]    offset;
        logic [LINE_BASE_BITS-1:0] base;
        logic                      do_write;

        kind_next      = kind_reg;
        owner_next     = owner_reg;
        held_addr_next = held_addr_reg;
        held_word_next = held_word_reg;
        phase_next     = phase_reg;
        merged_next    = merged_reg;
        res            = '0;
        res.owner_stage = owner_reg;
        want_kind      = (item.action == ACT_LOAD) ? KIND_LOAD : KIND_STORE;
        offset         = '0;
        base           = '0;
        do_write       = 1'b0;

        case (item.action) inside
            ACT_CANCEL:
            begin
                if ((kind_reg != KIND_NONE) && (owner_reg == item.requester))
                begin
                    res.mem_abort   = 1'b1;
                    res.owner_stage = '0;
                    kind_next       = KIND_NONE;
                    owner_next      = '0;
                    held_addr_next  = '0;
                    held_word_next  = '0;
                    phase_next      = 1'b0;
                end
            end
            ACT_LOAD, ACT_STORE:
            begin
                // an idle port is claimed by the first request
                if (kind_reg == KIND_NONE)
                begin
                    kind_next      = want_kind;
                    owner_next     = item.requester;
                    held_addr_next = norm;
                    held_word_next = item.store_value;
                    phase_next     = 1'b0;
                end
                offset = held_addr_next[OFFSET_BITS-1:0];
                base   = LINE_BASE_BITS'({held_addr_next[ADDR_BITS-1:OFFSET_BITS],
                                          {OFFSET_BITS{1'b0}}});
                if ((owner_next != item.requester) || (held_addr_next != norm) ||
                    (kind_next != want_kind))
                begin
                    res.must_wait   = 1'b1;
                    res.owner_stage = owner_next;
                end
                else if (kind_next == KIND_LOAD)
                begin
                    res.mem_read  = 1'b1;
                    res.line_base = base;
                    if (!item.read_ready)
                    begin
                        res.must_wait   = 1'b1;
                        res.owner_stage = owner_next;
                    end
                    else
                    begin
                        res.load_value  = item.line_word[offset];
                        res.owner_stage = '0;
                        kind_next       = KIND_NONE;
                        owner_next      = '0;
                        held_addr_next  = '0;
                        held_word_next  = '0;
                        phase_next      = 1'b0;
                    end
                end
                else
                begin
                    do_write = 1'b1;
                    if (!phase_next)
                    begin
                        res.mem_read  = 1'b1;
                        res.line_base = base;
                        if (!item.read_ready)
                        begin
                            res.must_wait   = 1'b1;
                            res.owner_stage = owner_next;
                            do_write        = 1'b0;
                        end
                        else
                        begin
                            merged_next         = item.line_word;
                            merged_next[offset] = held_word_next;
                            phase_next          = 1'b1;
                        end
                    end
                    if (do_write)
                    begin
                        res.mem_write  = 1'b1;
                        res.line_base  = base;
                        res.write_word = merged_next;
                        if (!item.write_ready)
                        begin
                            res.must_wait   = 1'b1;
                            res.owner_stage = owner_next;
                        end
                        else
                        begin
                            res.owner_stage = '0;
                            kind_next       = KIND_NONE;
                            owner_next      = '0;
                            held_addr_next  = '0;
                            held_word_next  = '0;
                            phase_next      = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                res.owner_stage = owner_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_NONE;
            owner_reg     <= '0;
            held_addr_reg <= '0;
            held_word_reg <= '0;
            phase_reg     <= 1'b0;
        end
        else if (commit)
        begin
            kind_reg      <= kind_next;
            owner_reg     <= owner_next;
            held_addr_reg <= held_addr_next;
            held_word_reg <= held_word_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            merged_reg <= merged_next;
        end
    end

endmodule

// ----- hw/rtl/single_owner_rmw_memory_port.sv -----
// top level of the single-owner read-modify-write memory port
//
// input channel: one request beat (action, requester, address, store_value,
//   memory ready flags and the returned line) moves on in_valid && !in_stall
// output channel: one result beat per request (wait flag, loaded word, owner,
//   memory commands, line base and merged line) moves on out_valid && !out_stall
// config channel: line_count is written on cfg_valid && cfg_ready, only while idle
// load and store beats wrap their address through a shared restoring remainder
//   unit, one quotient bit per cycle over the 30 line-index bits, plus a fold
//   step; the result is loaded once the unit is done and the output register is
//   free, and the next beat is accepted only after that load
// cancel and unused actions skip the remainder unit and go straight to the
//   done state
// one beat is in work at a time; in_stall is high from accept until the result
//   is loaded into the output register
// a result waiting on a stalled receiver does not block the next accept; the
//   finished beat after it holds until the output register frees
// reset frees the port, clears out_valid and sets line_count to 256
module single_owner_rmw_memory_port
    import sorm_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ACTION_BITS-1:0]          action,
    input  logic [STAGE_BITS-1:0]           requester,
    input  logic signed [RAW_ADDR_BITS-1:0] address,
    input  logic signed [WORD_BITS-1:0]     store_value,
    input  logic                            read_ready,
    input  logic                            write_ready,
    input  logic signed [WORD_BITS-1:0]     line_word0,
    input  logic signed [WORD_BITS-1:0]     line_word1,
    input  logic signed [WORD_BITS-1:0]     line_word2,
    input  logic signed [WORD_BITS-1:0]     line_word3,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            must_wait,
    output logic signed [WORD_BITS-1:0]     load_value,
    output logic [STAGE_BITS-1:0]           owner_stage,
    output logic                            mem_read,
    output logic                            mem_write,
    output logic                            mem_abort,
    output logic [LINE_BASE_BITS-1:0]       line_base,
    output logic signed [WORD_BITS-1:0]     write_word0,
    output logic signed [WORD_BITS-1:0]     write_word1,
    output logic signed [WORD_BITS-1:0]     write_word2,
    output logic signed [WORD_BITS-1:0]     write_word3,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [LINE_COUNT_BITS-1:0]      line_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WRAP = 3'b010,
        S_DONE = 3'b100
    } top_state_t;

    top_state_t                 state_reg, state_next;
    logic [LINE_COUNT_BITS-1:0] line_count_reg;
    item_t                      item_reg;
    result_t                    out_reg;
    logic                       out_valid_reg, out_valid_next;

    item_t                      item_in;
    result_t                    step_res;
    logic                       in_accept;
    logic                       wrap_start;
    logic                       wrap_done;
    logic [ADDR_BITS-1:0]       wrap_norm;
    logic                       out_free;
    logic                       commit;

    assign item_in.action       = action;
    assign item_in.requester    = requester;
    assign item_in.address      = address;
    assign item_in.store_value  = store_value;
    assign item_in.read_ready   = read_ready;
    assign item_in.write_ready  = write_ready;
    assign item_in.line_word[0] = line_word0;
    assign item_in.line_word[1] = line_word1;
    assign item_in.line_word[2] = line_word2;
    assign item_in.line_word[3] = line_word3;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);

    // only load and store beats need a wrapped address
    assign wrap_start = in_accept && ((action == ACT_LOAD) || (action == ACT_STORE));

    // output register takes a new beat when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (wrap_start)
                begin
                    state_next = S_WRAP;
                end
                else if (in_accept)
                begin
                    state_next = S_DONE;
                end
            end
            S_WRAP:
            begin
                if (wrap_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            line_count_reg <= LINE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                line_count_reg <= line_count;
            end
        end
    end

    // request payload is captured at accept, result payload at commit
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= item_in;
        end
        if (commit)
        begin
            out_reg <= step_res;
        end
    end

    sorm_wrap u_wrap (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (wrap_start),
        .address    (address),
        .line_count (line_count_reg),
        .done       (wrap_done),
        .norm       (wrap_norm)
    );

    sorm_port u_port (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (item_reg),
        .norm   (wrap_norm),
        .res    (step_res)
    );

    assign out_valid   = out_valid_reg;
    assign must_wait   = out_reg.must_wait;
    assign load_value  = out_reg.load_value;
    assign owner_stage = out_reg.owner_stage;
    assign mem_read    = out_reg.mem_read;
    assign mem_write   = out_reg.mem_write;
    assign mem_abort   = out_reg.mem_abort;
    assign line_base   = out_reg.line_base;
    assign write_word0 = out_reg.write_word[0];
    assign write_word1 = out_reg.write_word[1];
    assign write_word2 = out_reg.write_word[2];
    assign write_word3 = out_reg.write_word[3];

`ifndef ASSERT_OFF
    // a result never overwrites one the receiver has not taken
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(out_valid_reg && out_stall))
        else $error("result committed over a stalled beat");

    // the remainder unit only finishes while the sequencer waits for it
    a_wrap_owned: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_done |-> (state_reg == S_WRAP))
        else $error("wrap unit finished outside the wrap state");

    // an abort never travels with a line access
    a_abort_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.mem_abort && (out_reg.mem_read || out_reg.mem_write)))
        else $error("abort issued together with a line access");

    // line base is zero unless a line read or write goes out
    a_base_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.mem_read && !out_reg.mem_write) |-> (out_reg.line_base == '0))
        else $error("line base set without a line access");
`endif

endmodule
